[rtl/tafc_pkg.sv]
// Shared types and constants for the three-axis force calibration block.
package tafc_pkg;

    localparam int RegCount = 8;
    localparam int AddrBits = 6;
    localparam int ForceBits = 32;
    localparam int SumBits = 48;
    localparam int CoefBits = 20;
    localparam int CoefRegBits = 60;

    localparam logic [2:0] RegCalMode = 3'd0;
    localparam logic [2:0] RegInvert = 3'd1;
    localparam logic [2:0] RegRow0 = 3'd2;
    localparam logic [2:0] RegRow1 = 3'd3;
    localparam logic [2:0] RegRow2 = 3'd4;
    localparam logic [2:0] RegPolyX = 3'd5;
    localparam logic [2:0] RegPolyY = 3'd6;
    localparam logic [2:0] RegPolyZ = 3'd7;

    localparam logic [1:0] ModeRaw = 2'd0;
    localparam logic [1:0] ModeMatrix = 2'd1;
    localparam logic [1:0] ModePoly = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic signed [23:0] x_raw;
        logic signed [23:0] y_raw;
        logic signed [23:0] z_raw;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] x_force;
        logic signed [31:0] y_force;
        logic signed [31:0] z_force;
        logic               tare_done;
        logic               clipped;
    } result_t;

    // One queued job: raw sample plus the decoded request kind.
    typedef struct packed {
        logic               tare;
        logic               last;
        logic signed [23:0] x_raw;
        logic signed [23:0] y_raw;
        logic signed [23:0] z_raw;
    } job_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic [2:0]               invert;
        logic [3*CoefRegBits-1:0] matrix;
        logic [3*CoefRegBits-1:0] poly;
    } cfg_t;

endpackage

[rtl/tafc_front.sv]
// Front end: accepts samples, sign-extends and classifies them into a two-entry job queue.
module tafc_front
    import tafc_pkg::*;
#(
    parameter int ADC_BITS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  sample_t in_data,
    output logic    job_valid,
    input  logic    job_take,
    output job_t    job
);

    job_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    job_t       enq;
    logic       push;
    logic       pop;

    function automatic logic signed [23:0] ext(input logic [23:0] v);
        logic [23:0] r;
        begin
            r = v;
            for (int b = 0; b < 24; b++)
            begin
                if (b >= ADC_BITS)
                begin
                    r[b] = v[ADC_BITS-1];
                end
            end
            ext = r;
        end
    endfunction

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop = job_valid && job_take;
    assign job = q_reg[rd_reg];

    always_comb
    begin
        enq.tare = in_data.req_type;
        enq.last = in_data.last;
        enq.x_raw = ext(in_data.x_raw);
        enq.y_raw = ext(in_data.y_raw);
        enq.z_raw = ext(in_data.z_raw);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= enq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/tafc_divider.sv]
// Restoring divider for tare averaging: signed 48-bit sum by unsigned count, one bit a cycle.
module tafc_divider
    import tafc_pkg::*;
#(
    parameter int TARE_COUNT_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SumBits-1:0]  dividend,
    input  logic [TARE_COUNT_BITS-1:0] divisor,
    output logic                       done,
    output logic signed [31:0]         quotient
);

    localparam int StepBits = $clog2(SumBits + 1);

    logic [SumBits-1:0]         quo_reg;
    logic [TARE_COUNT_BITS:0]   rem_reg;
    logic [TARE_COUNT_BITS-1:0] den_reg;
    logic                       neg_reg;
    logic [StepBits-1:0]        step_reg;
    logic                       busy_reg;
    logic [TARE_COUNT_BITS:0]   trial;
    logic [TARE_COUNT_BITS:0]   shifted;
    logic [SumBits-1:0]         mag;
    logic [SumBits-1:0]         sq;

    assign mag = dividend[SumBits-1] ? (~dividend + 1'b1) : dividend;
    assign shifted = {rem_reg[TARE_COUNT_BITS-1:0], quo_reg[SumBits-1]};
    assign trial = shifted - {1'b0, den_reg};
    assign sq = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = sq[31:0];
    assign done = busy_reg && (step_reg == StepBits'(0));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[SumBits-1];
        end
        else if (busy_reg && step_reg != StepBits'(0))
        begin
            if (!trial[TARE_COUNT_BITS])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SumBits-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[SumBits-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= StepBits'(SumBits);
        end
        else if (busy_reg)
        begin
            if (step_reg == StepBits'(0))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/tafc_back.sv]
// Back end: sequenced calibration on a time-shared coefficient multiplier, tare bookkeeping and result register.
module tafc_back
    import tafc_pkg::*;
#(
    parameter int COEF_FRAC_BITS  = 16,
    parameter int TARE_COUNT_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    job_valid,
    output logic    job_take,
    input  job_t    job,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_AXIS  = 7'b0001000,
        S_FIN   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    localparam logic [63:0] Half = 64'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [63:0] BigLim = 64'(1) << 62;
    localparam logic [TARE_COUNT_BITS-1:0] CountMax = '1;

    state_t             state_reg;
    job_t               job_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         term_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [47:0]        sq_reg;
    logic [63:0]        plo_reg;
    logic [63:0]        phi_reg;
    logic signed [63:0] val_reg [3];
    logic signed [31:0] offset_reg [3];
    logic signed [SumBits-1:0] sum_reg [3];
    logic [TARE_COUNT_BITS-1:0] count_reg;
    logic               active_reg;
    logic               clip_reg;
    logic               tdone_reg;
    logic               ovalid_reg;
    result_t            out_reg;
    logic               div_start_reg;

    logic [1:0]          mode;
    logic signed [23:0]  xs [3];
    logic signed [23:0]  xa;
    logic [CoefRegBits-1:0] row;
    logic signed [19:0]  cf;
    logic signed [19:0]  a2;
    logic [23:0]         mx;
    logic [19:0]         ma;
    logic signed [43:0]  mprod;
    logic [63:0]         sqm;
    logic [63:0]         rabs;
    logic [63:0]         rmag;
    logic signed [63:0]  rsc;
    logic [63:0]         slo;
    logic [63:0]         smag;
    logic signed [63:0]  sterm;
    logic signed [63:0]  vfull;
    logic signed [63:0]  w;
    logic signed [63:0]  wsel;
    logic signed [31:0]  s32;
    logic signed [31:0]  f32;
    logic                sclip;
    logic                fclip;
    logic                ddone;
    logic signed [31:0]  dquo;
    logic signed [SumBits-1:0] dsum;

    function automatic logic signed [31:0] sat(input logic signed [63:0] v, output logic c);
        begin
            c = 1'b0;
            sat = v[31:0];
            if (v > 64'sd2147483647)
            begin
                c = 1'b1;
                sat = 32'sh7fffffff;
            end
            else if (v < -64'sd2147483648)
            begin
                c = 1'b1;
                sat = 32'sh80000000;
            end
        end
    endfunction

    assign mode = cfg.mode;
    assign xs[0] = job_reg.x_raw;
    assign xs[1] = job_reg.y_raw;
    assign xs[2] = job_reg.z_raw;
    assign job_take = (state_reg == S_IDLE) && job_valid;
    assign out_valid = ovalid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        xa = xs[axis_reg];
        if (mode == ModeMatrix)
        begin
            row = cfg.matrix[axis_reg*CoefRegBits +: CoefRegBits];
            cf = row[term_reg*CoefBits +: CoefBits];
            mprod = cf * xs[term_reg];
        end
        else
        begin
            row = cfg.poly[axis_reg*CoefRegBits +: CoefRegBits];
            cf = row[CoefBits +: CoefBits];
            mprod = cf * xa;
        end
        a2 = row[2*CoefBits +: CoefBits];
        ma = a2[19] ? 20'(-a2) : 20'(a2);
        mx = xa[23] ? 24'(-xa) : 24'(xa);
        sqm = 64'(sq_reg);
        rabs = acc_reg[63] ? (~acc_reg + 1'b1) : acc_reg;
        rmag = (rabs + Half) >> COEF_FRAC_BITS;
        rsc = acc_reg[63] ? -$signed(rmag) : $signed(rmag);
        slo = plo_reg + Half;
        if (phi_reg > (BigLim >> (32 - COEF_FRAC_BITS)))
        begin
            smag = BigLim;
        end
        else
        begin
            smag = (phi_reg << (32 - COEF_FRAC_BITS)) + (slo >> COEF_FRAC_BITS);
        end
        if (smag > BigLim)
        begin
            smag = BigLim;
        end
        sterm = a2[19] ? -$signed(smag) : $signed(smag);
        if (mode == ModeMatrix)
        begin
            vfull = rsc;
        end
        else if (mode == ModePoly)
        begin
            vfull = 64'(signed'(row[CoefBits-1:0])) + rsc + sterm;
        end
        else
        begin
            vfull = 64'(xa);
        end
        s32 = sat(vfull, sclip);
        w = val_reg[axis_reg] - 64'(offset_reg[axis_reg]);
        wsel = cfg.invert[axis_reg] ? -w : w;
        f32 = sat(wsel, fclip);
        dsum = sum_reg[axis_reg];
    end

    tafc_divider #(.TARE_COUNT_BITS(TARE_COUNT_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dsum),
        .divisor  (count_reg),
        .done     (ddone),
        .quotient (dquo)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mprod);
        plo_reg <= 64'(ma) * {32'd0, sqm[31:0]};
        phi_reg <= 64'(ma) * {48'd0, sqm[47:32]};
        if (state_reg == S_IDLE)
        begin
            job_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= '0;
            term_reg <= '0;
            acc_reg <= '0;
            sq_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                val_reg[i] <= '0;
                offset_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            count_reg <= '0;
            active_reg <= 1'b0;
            clip_reg <= 1'b0;
            tdone_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            out_reg <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        axis_reg <= '0;
                        term_reg <= '0;
                        acc_reg <= '0;
                        clip_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // Product of the previous cycle lands in prod_reg; one term per pass.
                    sq_reg <= 48'(mx) * 48'(mx);
                    term_reg <= term_reg + 1'b1;
                    if (term_reg != 2'd0)
                    begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    if ((mode == ModeMatrix && term_reg == 2'd3)
                        || (mode != ModeMatrix && term_reg == 2'd1))
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    // plo_reg and phi_reg come from sq_reg this cycle.
                    state_reg <= S_AXIS;
                end
                S_AXIS:
                begin
                    // Tare sums take the saturated value; measurements keep full range.
                    val_reg[axis_reg] <= job_reg.tare ? 64'(s32) : vfull;
                    acc_reg <= '0;
                    term_reg <= '0;
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_FIN:
                begin
                    if (job_reg.tare)
                    begin
                        if (!active_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                sum_reg[i] <= SumBits'(val_reg[i]);
                                offset_reg[i] <= '0;
                            end
                            count_reg <= TARE_COUNT_BITS'(1);
                            active_reg <= 1'b1;
                        end
                        else if (count_reg != CountMax)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                sum_reg[i] <= sum_reg[i] + SumBits'(val_reg[i]);
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                        if (job_reg.last)
                        begin
                            axis_reg <= '0;
                            div_start_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (!ovalid_reg || !out_stall)
                    begin
                        // Offset, invert, saturate one axis per cycle unless stalled; raw mode copies input.
                        if (mode == ModeRaw || mode == 2'd3)
                        begin
                            offset_reg[axis_reg] <= offset_reg[axis_reg];
                            val_reg[axis_reg] <= 64'(xs[axis_reg]);
                        end
                        else
                        begin
                            val_reg[axis_reg] <= 64'(f32);
                            clip_reg <= clip_reg | fclip;
                        end
                        tdone_reg <= 1'b0;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= S_OUT;
                        end
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (ddone)
                    begin
                        offset_reg[axis_reg] <= dquo;
                        val_reg[axis_reg] <= 64'(dquo);
                        if (axis_reg == 2'd2)
                        begin
                            active_reg <= 1'b0;
                            tdone_reg <= 1'b1;
                            clip_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        out_reg.x_force <= val_reg[0][31:0];
                        out_reg.y_force <= val_reg[1][31:0];
                        out_reg.z_force <= val_reg[2][31:0];
                        out_reg.tare_done <= tdone_reg;
                        out_reg.clipped <= clip_reg;
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/tafc_regs.sv]
// APB register file holding mode, inversion mask and coefficient rows.
module tafc_regs
    import tafc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output cfg_t                cfg
);

    logic [63:0] regs_reg [RegCount];
    logic [2:0]  idx;
    logic        wr;

    assign idx = paddr[5:3];
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);
    assign prdata = regs_reg[idx];
    assign cfg.mode = regs_reg[RegCalMode][1:0];
    assign cfg.invert = regs_reg[RegInvert][2:0];
    assign cfg.matrix = {regs_reg[RegRow2][59:0], regs_reg[RegRow1][59:0],
                         regs_reg[RegRow0][59:0]};
    assign cfg.poly = {regs_reg[RegPolyZ][59:0], regs_reg[RegPolyY][59:0],
                       regs_reg[RegPolyX][59:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RegCount; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (wr)
        begin
            case (idx)
                RegCalMode: regs_reg[idx] <= {62'd0, pwdata[1:0]};
                RegInvert:  regs_reg[idx] <= {61'd0, pwdata[2:0]};
                default:    regs_reg[idx] <= {4'd0, pwdata[59:0]};
            endcase
        end
    end

endmodule

[rtl/three_axis_force_calibration_top.sv]
// Three-axis load-cell calibration: raw, matrix or quadratic mode with tare offsets.
// In the back end, the shared 20x24 multiplier works through the matrix or polynomial
// terms one at a time, so matrix mode runs more multiply passes than raw and polynomial
// modes. A tare run's last sample adds three 48-step divisions on one divider.
// A two-entry queue lets the front take samples while the back end works.
module three_axis_force_calibration_top
    import tafc_pkg::*;
#(
    parameter int ADC_BITS        = 24,
    parameter int COEF_FRAC_BITS  = 16,
    parameter int TARE_COUNT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  sample_t             in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output result_t             out_data
);

    cfg_t cfg;
    job_t job;
    logic job_valid;
    logic job_take;

    tafc_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    tafc_front #(.ADC_BITS(ADC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .job_valid(job_valid), .job_take(job_take), .job(job)
    );

    tafc_back #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .TARE_COUNT_BITS(TARE_COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .job_valid(job_valid), .job_take(job_take),
        .job(job), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

[rtl/tafc_checker.sv]
// Port-level checker for the calibration block, bound to the top level.
module tafc_checker
    import tafc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    out_valid,
    input logic    out_stall,
    input result_t out_data,
    input logic    pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_tare_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tare_done |-> !out_data.clipped)
        else $error("tare result flagged clipped");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid || rst_n)
        else $error("result during reset");

endmodule

bind three_axis_force_calibration_top tafc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .pready(pready)
);
